@@ hw/rtl/sfr_pkg.sv @@
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int NUM_SEGS   = 7;
    localparam int LEVEL_W    = 8;
    localparam int MAX_DIGITS = 8;
    localparam int COUNT_W    = $clog2(MAX_DIGITS + 2);
    localparam int VALUE_W    = 27;
    localparam int MAXREAD_W  = 28;
    localparam int THRESH_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    localparam logic [LEVEL_W-1:0]   LEVEL_MAX = 8'd255;
    localparam logic [NUM_SEGS-1:0]  DASH_MASK = 7'h40;
    localparam logic [COUNT_W-1:0]   DIGIT_LIMIT = COUNT_W'(MAX_DIGITS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_LEVELS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_LEVEL       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_READING     = 2'd3;

    // configuration reset values
    localparam logic [THRESH_W-1:0]  FIXED_THRESHOLD_RST = 9'h1FF;
    localparam logic [LEVEL_W-1:0]   OFF_LEVEL_RST       = 8'd40;
    localparam logic [MAXREAD_W-1:0] MAX_READING_RST     = 28'hFFFFFFF;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_OFF   = 2'd1,
        STATUS_READY = 2'd2,
        STATUS_FAIL  = 2'd3
    } status_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] seg_a;
        logic [LEVEL_W-1:0] seg_b;
        logic [LEVEL_W-1:0] seg_c;
        logic [LEVEL_W-1:0] seg_d;
        logic [LEVEL_W-1:0] seg_e;
        logic [LEVEL_W-1:0] seg_f;
        logic [LEVEL_W-1:0] seg_g;
        logic [LEVEL_W-1:0] background_one;
        logic [LEVEL_W-1:0] background_two;
        logic               last_digit;
    } digit_t;

    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] reading;
    } result_t;

    // first stage summary handed from the merge stage to the frame logic
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [LEVEL_W-1:0] digit_peak;
        logic [LEVEL_W-1:0] thresh;
    } stage_t;

    typedef struct packed {
        logic       known;
        logic [3:0] digit;
    } decode_t;

    // segment mask to decimal digit, alternate shapes of 6, 7 and 9 included
    function automatic decode_t decode_mask(input logic [NUM_SEGS-1:0] mask);
        decode_t d;
        d.known = 1'b1;
        d.digit = 4'd0;
        case (mask)
            7'h3F: d.digit = 4'd0;
            7'h06: d.digit = 4'd1;
            7'h5B: d.digit = 4'd2;
            7'h4F: d.digit = 4'd3;
            7'h66: d.digit = 4'd4;
            7'h6D: d.digit = 4'd5;
            7'h7D: d.digit = 4'd6;
            7'h7C: d.digit = 4'd6;
            7'h07: d.digit = 4'd7;
            7'h27: d.digit = 4'd7;
            7'h7F: d.digit = 4'd8;
            7'h6F: d.digit = 4'd9;
            7'h67: d.digit = 4'd9;
            default: d.known = 1'b0;
        endcase
        return d;
    endfunction

endpackage

@@ hw/rtl/sfr_lane.sv @@
`timescale 1ns / 1ps

module sfr_lane
(
    input  logic                        clk,
    input  logic                        load,
    input  logic [sfr_pkg::LEVEL_W-1:0] sample,
    input  logic                        invert,
    input  logic [sfr_pkg::LEVEL_W-1:0] thresh,
    output logic [sfr_pkg::LEVEL_W-1:0] level,
    output logic                        seg_on
);

    logic [sfr_pkg::LEVEL_W-1:0] level_reg;

    // optional inversion, 255 - x is the bitwise complement
    assign level = invert ? (sfr_pkg::LEVEL_MAX - sample) : sample;

    // hold the level for the classification stage
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            level_reg <= level;
        end
    end

    // segment lit at or above the threshold
    assign seg_on = (level_reg >= thresh);

endmodule

@@ hw/rtl/sfr_merge.sv @@
`timescale 1ns / 1ps

module sfr_merge
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           load,
    input  logic                                           last_digit,
    input  logic [sfr_pkg::NUM_SEGS-1:0][sfr_pkg::LEVEL_W-1:0] levels,
    input  logic [sfr_pkg::LEVEL_W-1:0]                    background_one,
    input  logic [sfr_pkg::LEVEL_W-1:0]                    background_two,
    input  logic                                           invert,
    input  logic [sfr_pkg::THRESH_W-1:0]                   fixed_threshold,
    output sfr_pkg::stage_t                                stage
);

    logic [sfr_pkg::LEVEL_W-1:0] digit_peak;
    logic [sfr_pkg::LEVEL_W:0]   back_sum;
    logic [sfr_pkg::LEVEL_W-1:0] black_raw;
    logic [sfr_pkg::LEVEL_W-1:0] black;
    logic [sfr_pkg::LEVEL_W:0]   auto_sum;
    logic [sfr_pkg::LEVEL_W-1:0] thresh;

    logic                        valid_reg;
    logic                        last_reg;
    logic [sfr_pkg::LEVEL_W-1:0] digit_peak_reg;
    logic [sfr_pkg::LEVEL_W-1:0] thresh_reg;

    // brightest segment across the lanes
    always_comb
    begin
        digit_peak = levels[0];
        for (int i = 1; i < sfr_pkg::NUM_SEGS; i++)
        begin
            if (levels[i] > digit_peak)
            begin
                digit_peak = levels[i];
            end
        end
    end

    // background average, inverted after averaging
    assign back_sum  = {1'b0, background_one} + {1'b0, background_two};
    assign black_raw = back_sum[sfr_pkg::LEVEL_W:1];
    assign black     = invert ? (sfr_pkg::LEVEL_MAX - black_raw) : black_raw;

    // fixed threshold when non-negative, otherwise midpoint of black and peak
    assign auto_sum = {1'b0, black} + {1'b0, digit_peak};
    assign thresh   = fixed_threshold[sfr_pkg::THRESH_W-1]
                    ? auto_sum[sfr_pkg::LEVEL_W:1]
                    : fixed_threshold[sfr_pkg::LEVEL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg       <= last_digit;
            digit_peak_reg <= digit_peak;
            thresh_reg     <= thresh;
        end
    end

    assign stage.valid      = valid_reg;
    assign stage.last       = last_reg;
    assign stage.digit_peak = digit_peak_reg;
    assign stage.thresh     = thresh_reg;

endmodule

@@ hw/rtl/sfr_frame.sv @@
`timescale 1ns / 1ps

module sfr_frame
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sfr_pkg::stage_t               stage,
    input  logic [sfr_pkg::NUM_SEGS-1:0]  seg_on,
    input  logic [sfr_pkg::LEVEL_W-1:0]   off_level,
    input  logic [sfr_pkg::MAXREAD_W-1:0] max_reading,
    output logic                          done,
    output sfr_pkg::result_t              result
);

    // running frame state
    logic [sfr_pkg::VALUE_W-1:0] value_sum_reg,   value_sum_next;
    logic [sfr_pkg::LEVEL_W-1:0] peak_level_reg,  peak_level_next;
    logic                        all_blank_reg,   all_blank_next;
    logic                        all_dash_reg,    all_dash_next;
    logic                        bad_digit_reg,   bad_digit_next;
    logic [sfr_pkg::COUNT_W-1:0] digits_seen_reg, digits_seen_next;

    // end of frame snapshot
    logic                        snap_valid_reg;
    logic [sfr_pkg::VALUE_W-1:0] snap_sum_reg;
    logic [sfr_pkg::LEVEL_W-1:0] snap_peak_reg;
    logic                        snap_blank_reg;
    logic                        snap_dash_reg;
    logic                        snap_fail_reg;

    logic                        done_reg;
    sfr_pkg::result_t            result_reg, result_next;

    sfr_pkg::decode_t            dec;
    logic [sfr_pkg::VALUE_W+3:0] scaled;
    logic                        over_max;

    // mask decode and multiply-accumulate by ten
    assign dec    = sfr_pkg::decode_mask(seg_on);
    assign scaled = ({4'd0, value_sum_reg} << 3) + ({4'd0, value_sum_reg} << 1)
                  + {{(sfr_pkg::VALUE_W){1'b0}}, dec.digit};

    always_comb
    begin
        value_sum_next   = value_sum_reg;
        peak_level_next  = peak_level_reg;
        all_blank_next   = all_blank_reg;
        all_dash_next    = all_dash_reg;
        bad_digit_next   = bad_digit_reg;
        digits_seen_next = digits_seen_reg;

        if (stage.digit_peak > peak_level_reg)
        begin
            peak_level_next = stage.digit_peak;
        end
        if (seg_on != '0)
        begin
            all_blank_next = 1'b0;
        end
        if (seg_on != sfr_pkg::DASH_MASK)
        begin
            all_dash_next = 1'b0;
        end
        if (digits_seen_reg < sfr_pkg::DIGIT_LIMIT)
        begin
            if (!dec.known)
            begin
                bad_digit_next = 1'b1;
            end
            else
            begin
                value_sum_next = scaled[sfr_pkg::VALUE_W-1:0];
            end
        end
        if (digits_seen_reg <= sfr_pkg::DIGIT_LIMIT)
        begin
            digits_seen_next = digits_seen_reg + 1'b1;
        end
    end

    // frame state update, cleared after the last digit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_sum_reg   <= '0;
            peak_level_reg  <= '0;
            all_blank_reg   <= 1'b1;
            all_dash_reg    <= 1'b1;
            bad_digit_reg   <= 1'b0;
            digits_seen_reg <= '0;
            snap_valid_reg  <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= stage.valid && stage.last;
            if (stage.valid)
            begin
                if (stage.last)
                begin
                    value_sum_reg   <= '0;
                    peak_level_reg  <= '0;
                    all_blank_reg   <= 1'b1;
                    all_dash_reg    <= 1'b1;
                    bad_digit_reg   <= 1'b0;
                    digits_seen_reg <= '0;
                end
                else
                begin
                    value_sum_reg   <= value_sum_next;
                    peak_level_reg  <= peak_level_next;
                    all_blank_reg   <= all_blank_next;
                    all_dash_reg    <= all_dash_next;
                    bad_digit_reg   <= bad_digit_next;
                    digits_seen_reg <= digits_seen_next;
                end
            end
        end
    end

    // capture the finished frame
    always_ff @(posedge clk)
    begin
        if (stage.valid && stage.last)
        begin
            snap_sum_reg   <= value_sum_next;
            snap_peak_reg  <= peak_level_next;
            snap_blank_reg <= all_blank_next;
            snap_dash_reg  <= all_dash_next;
            snap_fail_reg  <= bad_digit_next || (digits_seen_next > sfr_pkg::DIGIT_LIMIT);
        end
    end

    // status priority: off, ready, fail, range check, ok
    assign over_max = !max_reading[sfr_pkg::MAXREAD_W-1]
                   && (snap_sum_reg > max_reading[sfr_pkg::VALUE_W-1:0]);

    always_comb
    begin
        result_next.reading = '0;
        if ((snap_peak_reg < off_level) || snap_blank_reg)
        begin
            result_next.status = sfr_pkg::STATUS_OFF;
        end
        else if (snap_dash_reg)
        begin
            result_next.status = sfr_pkg::STATUS_READY;
        end
        else if (snap_fail_reg || over_max)
        begin
            result_next.status = sfr_pkg::STATUS_FAIL;
        end
        else
        begin
            result_next.status  = sfr_pkg::STATUS_OK;
            result_next.reading = snap_sum_reg;
        end
    end

    // result transaction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ hw/rtl/seven_segment_frame_reader.sv @@
// result path: a last digit accepted at an edge passes the input lanes, the frame
//   update and the status register before the result strobe goes high
// throughput: one digit per cycle; busy stays low, the pipeline never stalls
// the receiver cannot stall, each result transaction lasts one cycle
// reset: asynchronous active low, clears frame state, pipeline valids and config
`timescale 1ns / 1ps

module seven_segment_frame_reader
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sfr_pkg::digit_t                digit,
    input  logic                           wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] wr_data,
    output logic                           done,
    output sfr_pkg::result_t               result
);

    logic [sfr_pkg::THRESH_W-1:0]  fixed_threshold_reg;
    logic                          invert_levels_reg;
    logic [sfr_pkg::LEVEL_W-1:0]   off_level_reg;
    logic [sfr_pkg::MAXREAD_W-1:0] max_reading_reg;

    logic                                               load;
    logic [sfr_pkg::NUM_SEGS-1:0][sfr_pkg::LEVEL_W-1:0] samples;
    logic [sfr_pkg::NUM_SEGS-1:0][sfr_pkg::LEVEL_W-1:0] levels;
    logic [sfr_pkg::NUM_SEGS-1:0]                       seg_on;
    sfr_pkg::stage_t                                    stage;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_threshold_reg <= sfr_pkg::FIXED_THRESHOLD_RST;
            invert_levels_reg   <= 1'b0;
            off_level_reg       <= sfr_pkg::OFF_LEVEL_RST;
            max_reading_reg     <= sfr_pkg::MAX_READING_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                sfr_pkg::CFG_FIXED_THRESHOLD: fixed_threshold_reg <= wr_data[sfr_pkg::THRESH_W-1:0];
                sfr_pkg::CFG_INVERT_LEVELS:   invert_levels_reg   <= wr_data[0];
                sfr_pkg::CFG_OFF_LEVEL:       off_level_reg       <= wr_data[sfr_pkg::LEVEL_W-1:0];
                sfr_pkg::CFG_MAX_READING:     max_reading_reg     <= wr_data[sfr_pkg::MAXREAD_W-1:0];
                default: ;
            endcase
        end
    end

    // fully pipelined, a digit enters every cycle
    assign busy = 1'b0;
    assign load = start && !busy;

    // segment a is lane 0
    assign samples[0] = digit.seg_a;
    assign samples[1] = digit.seg_b;
    assign samples[2] = digit.seg_c;
    assign samples[3] = digit.seg_d;
    assign samples[4] = digit.seg_e;
    assign samples[5] = digit.seg_f;
    assign samples[6] = digit.seg_g;

    // one lane per segment
    for (genvar i = 0; i < sfr_pkg::NUM_SEGS; i++)
    begin : g_lane
        sfr_lane u_lane
        (
            .clk    (clk),
            .load   (load),
            .sample (samples[i]),
            .invert (invert_levels_reg),
            .thresh (stage.thresh),
            .level  (levels[i]),
            .seg_on (seg_on[i])
        );
    end

    // peak and threshold across the lanes
    sfr_merge u_merge
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (load),
        .last_digit      (digit.last_digit),
        .levels          (levels),
        .background_one  (digit.background_one),
        .background_two  (digit.background_two),
        .invert          (invert_levels_reg),
        .fixed_threshold (fixed_threshold_reg),
        .stage           (stage)
    );

    // decode, accumulate and report
    sfr_frame u_frame
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .seg_on      (seg_on),
        .off_level   (off_level_reg),
        .max_reading (max_reading_reg),
        .done        (done),
        .result      (result)
    );

endmodule
